// ----- hdl/psd_pkg.sv -----
// Shared constants and types for the pending signal delivery unit.
// No dependencies; used by psd_pick and pending_signal_delivery_unit.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    typedef logic [4:0] dsig_t;
    typedef logic [1:0] opcode_t;
    typedef logic [1:0] action_t;

    localparam opcode_t OP_SEND    = 2'd0;
    localparam opcode_t OP_SET     = 2'd1;
    localparam opcode_t OP_DELIVER = 2'd2;
    localparam opcode_t OP_UNUSED  = 2'd3;

    localparam action_t ACT_ACK       = 2'd0;
    localparam action_t ACT_HANDLER   = 2'd1;
    localparam action_t ACT_TERMINATE = 2'd2;
    localparam action_t ACT_DISCARD   = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam int SIG_TERM_A = 9;
    localparam int SIG_TERM_B = 15;

endpackage

`default_nettype wire

// ----- hdl/pending_signal_delivery_unit.sv -----
// Top level of the pending signal delivery unit: control FSM and mask stores.
// Depends on psd_pkg, psd_ram and psd_pick.
//
//   Channel | Handshake               | Word
//   --------+-------------------------+------------------------------------------
//   in      | in_valid / in_stall     | opcode, proc_id, sig_num, handler_present
//   out     | out_valid / out_stall   | status, delivered_sig, action, last
//
// One item at a time. Send and set read the mask RAM (registered read) and
// write it back, then ack; an invalid or out-of-range request skips the read.
// A deliver reads the masks and acks when nothing is pending, else gives one
// result per cycle per pending signal while the output is not stalled.
// Reset clears both masks through per-process valid bits; no clearing pass.
// A stalled output holds the FSM in place; input stays stalled until idle.
`timescale 1ns / 1ps
`default_nettype none

module pending_signal_delivery_unit #(
    parameter int NUM_PROCESSES = 8,
    parameter int NUM_SIGNALS   = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire psd_pkg::opcode_t opcode,
    input  wire logic [3:0]       proc_id,
    input  wire logic [5:0]       sig_num,
    input  wire logic             handler_present,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  status,
    output psd_pkg::dsig_t        delivered_sig,
    output psd_pkg::action_t      action,
    output logic                  last
);

    localparam int PIDX_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int SIG_W  = $clog2(NUM_SIGNALS);
    localparam logic [6:0] NPROC_L = 7'(NUM_PROCESSES);
    localparam logic [6:0] NSIG_L  = 7'(NUM_SIGNALS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ACK,
        ST_DELIVER
    } state_t;

    state_t                   state_reg, state_next;
    psd_pkg::opcode_t         op_reg, op_next;
    logic [PIDX_W-1:0]        pid_reg, pid_next;
    logic [5:0]               sig_reg, sig_next;
    logic                     hp_reg, hp_next;
    logic                     ack_status_reg, ack_status_next;
    logic [NUM_SIGNALS-1:0]   work_pend_reg, work_pend_next;
    logic [NUM_SIGNALS-1:0]   work_hand_reg, work_hand_next;
    logic [NUM_PROCESSES-1:0] pend_vld_reg, pend_vld_next;
    logic [NUM_PROCESSES-1:0] hand_vld_reg, hand_vld_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     status_reg, status_next;
    psd_pkg::dsig_t           dsig_reg, dsig_next;
    psd_pkg::action_t         action_reg, action_next;
    logic                     last_reg, last_next;

    logic                     pend_we, hand_we;
    logic [NUM_SIGNALS-1:0]   pend_wdata, hand_wdata;
    logic [NUM_SIGNALS-1:0]   pend_rdata, hand_rdata;
    logic [NUM_SIGNALS-1:0]   pend_cur, hand_cur, sig_bit;
    logic [PIDX_W-1:0]        rd_addr;
    logic                     out_free, pid_ok, sig_ok, req_err;

    logic [SIG_W-1:0]         pick_sig;
    psd_pkg::action_t         pick_act;
    logic [NUM_SIGNALS-1:0]   pick_rest;
    logic                     pick_done;

    psd_ram #(
        .WIDTH(NUM_SIGNALS),
        .DEPTH(NUM_PROCESSES)
    ) u_pend_ram (
        .clk  (clk),
        .we   (pend_we),
        .waddr(pid_reg),
        .wdata(pend_wdata),
        .raddr(rd_addr),
        .rdata(pend_rdata)
    );

    psd_ram #(
        .WIDTH(NUM_SIGNALS),
        .DEPTH(NUM_PROCESSES)
    ) u_hand_ram (
        .clk  (clk),
        .we   (hand_we),
        .waddr(pid_reg),
        .wdata(hand_wdata),
        .raddr(rd_addr),
        .rdata(hand_rdata)
    );

    psd_pick #(
        .NUM_SIGNALS(NUM_SIGNALS)
    ) u_pick (
        .pend(work_pend_reg),
        .hand(work_hand_reg),
        .sig (pick_sig),
        .act (pick_act),
        .rest(pick_rest),
        .done(pick_done)
    );

    assign rd_addr  = PIDX_W'(proc_id);
    assign pid_ok   = ({3'b000, proc_id} < NPROC_L);
    assign sig_ok   = ({1'b0, sig_num} < NSIG_L);
    assign req_err  = (opcode == psd_pkg::OP_UNUSED) || !pid_ok ||
                      ((opcode == psd_pkg::OP_SEND || opcode == psd_pkg::OP_SET) && !sig_ok);
    assign out_free = !out_valid_reg || !out_stall;

    assign pend_cur = pend_vld_reg[pid_reg] ? pend_rdata : '0;
    assign hand_cur = hand_vld_reg[pid_reg] ? hand_rdata : '0;
    assign sig_bit  = {{(NUM_SIGNALS-1){1'b0}}, 1'b1} << sig_reg;

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign delivered_sig = dsig_reg;
    assign action        = action_reg;
    assign last          = last_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pid_next        = pid_reg;
        sig_next        = sig_reg;
        hp_next         = hp_reg;
        ack_status_next = ack_status_reg;
        work_pend_next  = work_pend_reg;
        work_hand_next  = work_hand_reg;
        pend_vld_next   = pend_vld_reg;
        hand_vld_next   = hand_vld_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        dsig_next       = dsig_reg;
        action_next     = action_reg;
        last_next       = last_reg;
        pend_we         = 1'b0;
        hand_we         = 1'b0;
        pend_wdata      = pend_cur | sig_bit;
        hand_wdata      = hp_reg ? (hand_cur | sig_bit) : (hand_cur & ~sig_bit);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = opcode;
                    pid_next = PIDX_W'(proc_id);
                    sig_next = sig_num;
                    hp_next  = handler_present;
                    if (req_err)
                    begin
                        ack_status_next = psd_pkg::STATUS_ERR;
                        state_next      = ST_ACK;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ack_status_next = psd_pkg::STATUS_OK;
                state_next      = ST_ACK;
                unique case (op_reg)
                    psd_pkg::OP_SEND:
                    begin
                        pend_we                = 1'b1;
                        pend_vld_next[pid_reg] = 1'b1;
                    end
                    psd_pkg::OP_SET:
                    begin
                        hand_we                = 1'b1;
                        hand_vld_next[pid_reg] = 1'b1;
                    end
                    default:
                    begin
                        if (pend_cur != '0)
                        begin
                            // clear the whole mask now; delivery drains a copy
                            pend_we                = 1'b1;
                            pend_wdata             = '0;
                            pend_vld_next[pid_reg] = 1'b1;
                            work_pend_next         = pend_cur;
                            work_hand_next         = hand_cur;
                            state_next             = ST_DELIVER;
                        end
                    end
                endcase
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ack_status_reg;
                    dsig_next      = '0;
                    action_next    = psd_pkg::ACT_ACK;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = psd_pkg::STATUS_OK;
                    dsig_next      = psd_pkg::dsig_t'(pick_sig);
                    action_next    = pick_act;
                    last_next      = pick_done;
                    work_pend_next = pick_rest;
                    if (pick_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= psd_pkg::OP_SEND;
            pid_reg        <= '0;
            sig_reg        <= '0;
            hp_reg         <= 1'b0;
            ack_status_reg <= psd_pkg::STATUS_OK;
            work_pend_reg  <= '0;
            work_hand_reg  <= '0;
            pend_vld_reg   <= '0;
            hand_vld_reg   <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= psd_pkg::STATUS_OK;
            dsig_reg       <= '0;
            action_reg     <= psd_pkg::ACT_ACK;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            pid_reg        <= pid_next;
            sig_reg        <= sig_next;
            hp_reg         <= hp_next;
            ack_status_reg <= ack_status_next;
            work_pend_reg  <= work_pend_next;
            work_hand_reg  <= work_hand_next;
            pend_vld_reg   <= pend_vld_next;
            hand_vld_reg   <= hand_vld_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            dsig_reg       <= dsig_next;
            action_reg     <= action_next;
            last_reg       <= last_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/psd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-process signal masks.
`timescale 1ns / 1ps
`default_nettype none

module psd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/psd_pick.sv -----
// Delivery picker: lowest pending signal, its action and the remaining mask.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_pick #(
    parameter int NUM_SIGNALS = 32
) (
    input  wire logic [NUM_SIGNALS-1:0]         pend,
    input  wire logic [NUM_SIGNALS-1:0]         hand,
    output logic      [$clog2(NUM_SIGNALS)-1:0] sig,
    output psd_pkg::action_t                    act,
    output logic      [NUM_SIGNALS-1:0]         rest,
    output logic                                done
);

    localparam int SIG_W = $clog2(NUM_SIGNALS);
    localparam logic [SIG_W-1:0] TERM_A = SIG_W'(psd_pkg::SIG_TERM_A);
    localparam logic [SIG_W-1:0] TERM_B = SIG_W'(psd_pkg::SIG_TERM_B);

    always_comb
    begin
        sig = '0;
        for (int i = NUM_SIGNALS - 1; i >= 0; i--)
        begin
            if (pend[i])
            begin
                sig = SIG_W'(i);
            end
        end
    end

    always_comb
    begin
        if (hand[sig])
        begin
            act = psd_pkg::ACT_HANDLER;
        end
        else if (sig == TERM_A || sig == TERM_B)
        begin
            act = psd_pkg::ACT_TERMINATE;
        end
        else
        begin
            act = psd_pkg::ACT_DISCARD;
        end
    end

    // drop the lowest set bit
    assign rest = pend & (pend - NUM_SIGNALS'(1));
    assign done = (rest == '0);

endmodule

`default_nettype wire
